// ===== hw/rtl/dpds_pkg.sv =====
package dpds_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned RANK_W     = 11;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned SUM_W      = 42;
  localparam int unsigned PROD_W     = POS_W + CNT_W;
  localparam int unsigned TOTAL_W    = 63;
  localparam int unsigned MEM_W      = CNT_W + SUM_W;
  localparam int unsigned RANK_SLOTS_DEF = 1024;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_QWAIT,
    ST_MUL,
    ST_UPDATE,
    ST_UWAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic query;
    logic mul;
    logic update;
    logic clear;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_over;
    logic clr_last;
  } sts_t;

endpackage

// ===== hw/rtl/dpds_ctrl.sv =====
module dpds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dpds_pkg::sts_t sts_i,
  output dpds_pkg::cmd_t cmd_o
);

  dpds_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpds_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpds_pkg::ST_CLEAR:  if (sts_i.clr_last) state_d = dpds_pkg::ST_IDLE;
      dpds_pkg::ST_IDLE:   if (in_valid_i) state_d = dpds_pkg::ST_QUERY;
      dpds_pkg::ST_QUERY:  if (sts_i.idx_zero) state_d = dpds_pkg::ST_QWAIT;
      dpds_pkg::ST_QWAIT:  state_d = dpds_pkg::ST_MUL;
      dpds_pkg::ST_MUL:    state_d = dpds_pkg::ST_UPDATE;
      dpds_pkg::ST_UPDATE: if (sts_i.idx_over) state_d = dpds_pkg::ST_UWAIT;
      dpds_pkg::ST_UWAIT:  state_d = dpds_pkg::ST_FIN;
      dpds_pkg::ST_FIN:    if (out_free) state_d = dpds_pkg::ST_IDLE;
      default:             state_d = dpds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      dpds_pkg::ST_CLEAR:  cmd_o.clear = 1'b1;
      dpds_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      dpds_pkg::ST_QUERY:  cmd_o.query = 1'b1;
      dpds_pkg::ST_QWAIT:  cmd_o = '0;
      dpds_pkg::ST_MUL:    cmd_o.mul = 1'b1;
      dpds_pkg::ST_UPDATE: cmd_o.update = 1'b1;
      dpds_pkg::ST_UWAIT:  cmd_o = '0;
      dpds_pkg::ST_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default:             cmd_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/dpds_datapath.sv =====
module dpds_datapath #(
  parameter int unsigned RANK_SLOTS = dpds_pkg::RANK_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dpds_pkg::POS_W-1:0]   position_i,
  input  logic [dpds_pkg::RANK_W-1:0]  speed_rank_i,
  input  dpds_pkg::cmd_t               cmd_i,
  output dpds_pkg::sts_t               sts_o,
  output logic [dpds_pkg::TOTAL_W-1:0] running_total_o
);

  // tree index reaches up to twice the slot count during the update walk
  localparam int unsigned IW = $clog2(RANK_SLOTS + 1) + 1;
  localparam int unsigned AW = $clog2(RANK_SLOTS);
  localparam logic [IW-1:0] SLOTS_I = IW'(RANK_SLOTS);
  localparam logic [AW-1:0] LAST_A  = AW'(RANK_SLOTS - 1);

  localparam int unsigned CW = dpds_pkg::CNT_W;
  localparam int unsigned SW = dpds_pkg::SUM_W;
  localparam int unsigned PW = dpds_pkg::PROD_W;
  localparam int unsigned TW = dpds_pkg::TOTAL_W;

  logic [dpds_pkg::MEM_W-1:0] mem [RANK_SLOTS];

  logic [dpds_pkg::POS_W-1:0] pos_q;
  logic [IW-1:0] rank_q, idx_q, idx_d;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] sum_q;
  logic [PW-1:0] prod_q, term_q;
  logic [TW-1:0] total_q;
  logic [AW-1:0] clr_addr_q, wb_addr_q, rd_addr;
  logic [dpds_pkg::MEM_W-1:0] rdata_q;
  logic rd_vld_q, rd_wb_q;
  logic rd_en;
  logic [IW-1:0] lowbit, idx_m1;
  logic [31:0] rank_w, rank_c;
  logic [CW-1:0] rd_cnt;
  logic [SW-1:0] rd_sum;
  logic [TW:0] total_sum;

  assign lowbit = idx_q & (~idx_q + IW'(1));
  assign idx_m1 = idx_q - IW'(1);
  assign rd_addr = idx_m1[AW-1:0];
  assign rd_cnt = rdata_q[dpds_pkg::MEM_W-1:SW];
  assign rd_sum = rdata_q[SW-1:0];

  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.idx_over = (idx_q > SLOTS_I);
  assign sts_o.clr_last = (clr_addr_q == LAST_A);

  assign rd_en = (cmd_i.query && !sts_o.idx_zero) || (cmd_i.update && !sts_o.idx_over);

  // out-of-range ranks fold onto the nearest valid slot
  always_comb begin
    rank_w = 32'(speed_rank_i);
    if (rank_w == 32'd0) begin
      rank_c = 32'd1;
    end else if (rank_w > 32'(RANK_SLOTS)) begin
      rank_c = 32'(RANK_SLOTS);
    end else begin
      rank_c = rank_w;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = rank_c[IW-1:0];
    end else if (cmd_i.mul) begin
      idx_d = rank_q;
    end else if (cmd_i.query && !sts_o.idx_zero) begin
      idx_d = idx_q - lowbit;
    end else if (cmd_i.update && !sts_o.idx_over) begin
      idx_d = idx_q + lowbit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      clr_addr_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_wb_q    <= 1'b0;
      total_q    <= '0;
    end else begin
      idx_q    <= idx_d;
      rd_vld_q <= rd_en;
      rd_wb_q  <= cmd_i.update;
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.finish) begin
        total_q <= (total_sum > {1'b0, dpds_pkg::TOTAL_MAX}) ? dpds_pkg::TOTAL_MAX
                                                             : total_sum[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q  <= position_i;
      rank_q <= rank_c[IW-1:0];
      cnt_q  <= '0;
      sum_q  <= '0;
    end else if (rd_vld_q && !rd_wb_q) begin
      cnt_q <= cnt_q + rd_cnt;
      sum_q <= sum_q + rd_sum;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(pos_q) * PW'(cnt_q);
    end
    term_q <= (prod_q >= PW'(sum_q)) ? (prod_q - PW'(sum_q)) : '0;
    if (rd_en) begin
      rdata_q   <= mem[rd_addr];
      wb_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_addr_q] <= '0;
    end else if (rd_vld_q && rd_wb_q) begin
      mem[wb_addr_q] <= {rd_cnt + CW'(1), rd_sum + SW'(pos_q)};
    end
  end

  assign total_sum = {1'b0, total_q} + (TW + 1)'(term_q);
  assign running_total_o = total_q;

endmodule

// ===== hw/rtl/dominated_pair_distance_sum.sv =====
// Running sum of distances over dominated point pairs. Items carry a position (ascending)
// and a speed rank; rank 0 counts as rank 1 and ranks above RANK_SLOTS as RANK_SLOTS.
// Counts and position sums live in one Fenwick tree memory of RANK_SLOTS words with one
// read and one write port. After reset the memory is swept clear, during which no item is
// taken. One item at a time: an item walks popcount(rank) tree nodes in its query, then
// does one read-modify-write per update level (up to log2(RANK_SLOTS)+1 levels). The
// total saturates at 2^63-1, and the next item may be accepted while the previous result
// waits in the output register; that item then holds in its final state until the
// waiting result is taken.
module dominated_pair_distance_sum #(
  parameter int unsigned RANK_SLOTS = dpds_pkg::RANK_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dpds_pkg::POS_W-1:0]   position_i,
  input  logic [dpds_pkg::RANK_W-1:0]  speed_rank_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dpds_pkg::TOTAL_W-1:0] running_total_o
);

  dpds_pkg::cmd_t cmd;
  dpds_pkg::sts_t sts;

  dpds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dpds_datapath #(
    .RANK_SLOTS (RANK_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .position_i      (position_i),
    .speed_rank_i    (speed_rank_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .running_total_o (running_total_o)
  );

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = dpds_pkg::RANK_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned LONG_HOLD   = 300;

  typedef logic [dpds_pkg::POS_W-1:0]   pos_t;
  typedef logic [dpds_pkg::RANK_W-1:0]  rank_t;
  typedef logic [dpds_pkg::TOTAL_W-1:0] total_t;
  typedef logic [dpds_pkg::CNT_W-1:0]   cnt_t;
  typedef logic [dpds_pkg::SUM_W-1:0]   sum_t;
  typedef logic [dpds_pkg::PROD_W-1:0]  prod_t;

  typedef struct {
    pos_t  position;
    rank_t speed_rank;
    bit    drain_first;
  } point_t;

  logic   clk = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready_o;
  pos_t   position = '0;
  rank_t  speed_rank = '0;
  logic   out_valid_o;
  logic   out_ready = 1'b0;
  total_t running_total_o;

  // software copy of the rank-indexed prefix trees
  cnt_t   count_by_rank [1:SLOTS];
  sum_t   possum_by_rank [1:SLOTS];
  total_t total_model = '0;

  point_t pending_points[$];
  total_t expected_totals[$];

  int unsigned total_points    = 0;
  int unsigned accepted_points = 0;
  int unsigned results_checked = 0;
  int unsigned ranks_clamped   = 0;
  int unsigned zero_terms      = 0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;
  int unsigned cycle_count     = 0;
  int unsigned errors          = 0;

  always #10 clk = ~clk;

  dominated_pair_distance_sum #(
    .RANK_SLOTS(SLOTS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .position_i     (position),
    .speed_rank_i   (speed_rank),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .running_total_o(running_total_o)
  );

  function automatic total_t accumulate_pair_distances(pos_t pos, rank_t rank);
    int unsigned idx;
    int unsigned i;
    cnt_t        cnt;
    sum_t        psum;
    prod_t       prod;
    logic [63:0] term;
    idx = 32'(rank);
    if (rank == 0 || rank > SLOTS) begin
      ranks_clamped++;
      idx = (rank == 0) ? 1 : SLOTS;
    end
    cnt  = '0;
    psum = '0;
    i    = idx;
    while (i >= 1) begin
      cnt  = cnt + count_by_rank[i];
      psum = psum + possum_by_rank[i];
      i    = i - (i & (~i + 1));
    end
    prod = prod_t'(pos) * prod_t'(cnt);
    if (prod >= prod_t'(psum)) begin
      term = 64'(prod - prod_t'(psum));
    end else begin
      term = '0;
      zero_terms++;
    end
    if (term > 64'(dpds_pkg::TOTAL_MAX - total_model)) begin
      total_model = dpds_pkg::TOTAL_MAX;
    end else begin
      total_model = total_model + total_t'(term);
    end
    i = idx;
    while (i <= SLOTS) begin
      count_by_rank[i]  = count_by_rank[i] + cnt_t'(1);
      possum_by_rank[i] = possum_by_rank[i] + sum_t'(pos);
      i = i + (i & (~i + 1));
    end
    return total_model;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic void add_point(pos_t pos, rank_t rank, bit drain);
    point_t p;
    p.position    = pos;
    p.speed_rank  = rank;
    p.drain_first = drain;
    pending_points.push_back(p);
    total_points++;
  endfunction

  // driver
  always @(posedge clk or negedge rst_ni) begin : driver_proc
    bit     send;
    point_t nxt;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      position   <= '0;
      speed_rank <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_totals.push_back(accumulate_pair_distances(position, speed_rank));
        accepted_points++;
      end
      if (!in_valid || in_ready_o) begin
        send = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_points.size() != 0 &&
                     !(pending_points[0].drain_first && expected_totals.size() != 0)) begin
          nxt        = pending_points.pop_front();
          position   <= nxt.position;
          speed_rank <= nxt.speed_rank;
          send       = 1'b1;
          // back-to-back burst for the first 25 of every hundred items
          send_gap   = (accepted_points % 100 < 25) ? 0 : pick_idle();
        end
        in_valid <= send;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk or negedge rst_ni) begin : monitor_proc
    total_t want;
    bit     ready_next;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_totals.size() == 0) begin
          $error("running_total result with no item pending: got %0d", running_total_o);
          errors++;
        end else begin
          want = expected_totals.pop_front();
          if (running_total_o !== want) begin
            $error("running_total mismatch: expected %0d, got %0d", want, running_total_o);
            errors++;
          end
        end
        results_checked++;
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && results_checked >= 150) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      ready_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        ready_next = 1'b1;
        if (results_checked % 100 >= 40 && $urandom_range(0, 5) == 0) begin
          stall_left = pick_idle();
        end
      end
      out_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d items accepted, %0d results pending",
               cycle_count, accepted_points, total_points, expected_totals.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    longint unsigned cursor;
    longint unsigned step;
    int unsigned     r;
    rank_t           rank;
    for (int i = 1; i <= SLOTS; i++) begin
      count_by_rank[i]  = '0;
      possum_by_rank[i] = '0;
    end

    // directed: rank extremes, clamping, deepest query paths, out-of-order drops
    add_point(32'd0,          11'd1,    1'b0);
    add_point(32'd0,          11'd1024, 1'b0);
    add_point(32'd5,          11'd0,    1'b0);
    add_point(32'd10,         11'd2047, 1'b0);
    add_point(32'd10,         11'd1025, 1'b0);
    add_point(32'd20,         11'd512,  1'b0);
    add_point(32'd21,         11'd511,  1'b0);
    add_point(32'd40,         11'd1023, 1'b0);
    add_point(32'd41,         11'd768,  1'b0);
    add_point(32'd100,        11'd1,    1'b0);
    add_point(32'd3,          11'd1024, 1'b0);
    add_point(32'd2,          11'd2,    1'b0);
    add_point(32'h0000_FFFF,  11'd1024, 1'b0);
    add_point(32'h7FFF_FFFF,  11'd640,  1'b0);
    add_point(32'hFFFF_FFFE,  11'd1023, 1'b0);
    add_point(32'hFFFF_FFFF,  11'd1024, 1'b0);
    add_point(32'hFFFF_FFFF,  11'd1,    1'b0);
    add_point(32'hFFFF_FFFF,  11'd1024, 1'b0);
    add_point(32'h8000_0000,  11'd3,    1'b0);

    // random: ascending runs with occasional restarts
    cursor = 0;
    for (int n = 0; n < 550; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cursor = $urandom;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70)      step = $urandom_range(0, 255);
        else if (r < 95) step = $urandom_range(0, 1 << 20);
        else             step = $urandom_range(0, 1 << 30);
        cursor = cursor + step;
        if (cursor > 64'hFFFF_FFFF) cursor = $urandom_range(0, 1000);
      end
      r = $urandom_range(0, 99);
      if (r < 30)      rank = rank_t'($urandom_range(1, 32));
      else if (r < 85) rank = rank_t'($urandom_range(1, SLOTS));
      else if (r < 90) rank = ($urandom_range(0, 1) != 0) ? rank_t'(SLOTS) : rank_t'(1);
      else if (r < 93) rank = '0;
      else             rank = rank_t'($urandom_range(SLOTS + 1, 2047));
      add_point(pos_t'(cursor), rank, (n == 0 || n == 200 || n == 420));
    end

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;

    while (accepted_points < total_points) @(posedge clk);
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d points streamed, %0d running totals compared, final total %0d",
             accepted_points, results_checked, total_model);
    $display("%0d ranks clamped into range, %0d out-of-order points added nothing",
             ranks_clamped, zero_terms);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dpds_pkg.sv
hw/rtl/dpds_ctrl.sv
hw/rtl/dpds_datapath.sv
hw/rtl/dominated_pair_distance_sum.sv
dv/testbench.sv
